@@ src/watlr_pkg.sv @@
`timescale 1ns / 1ps

package watlr_pkg;

  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_SAVE   = 3'd1,
    ACT_REMOVE = 3'd2,
    ACT_SET_EN = 3'd3,
    ACT_CLEAR  = 3'd4
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_START_A,
    ST_START_B,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_FINISH
  } state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic scan_rd;
    logic scan_cmp;
    logic start_a;
    logic start_b;
    logic move_rd;
    logic move_wr;
    logic finish;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic need_scan;
    logic need_move;
    logic scan_end;
    logic scan_hit;
    logic out_busy;
  } stat_t;

  localparam logic [7:0]  FULL_LEVEL      = 8'd255;
  localparam logic [15:0] STEP_RESET      = 16'd3529;
  localparam logic [23:0] HOLD_RESET      = 24'd2400000;
  localparam logic [15:0] CHECK_RESET     = 16'd3000;
  localparam logic [15:0] MS_PER_MIN      = 16'd60000;
  // rise*60000/255 = rise*235 + floor(rise*5/17); the fraction uses 241/4096 for 1/17
  localparam logic [7:0]  RISE_INT_MULT   = 8'd235;
  localparam logic [10:0] RISE_FRAC_MULT  = 11'd1205;
  localparam int          RISE_FRAC_SHIFT = 12;
  localparam logic [7:0]  ENABLE_ON       = 8'd1;

endpackage

@@ src/watlr_ctrl.sv @@
`timescale 1ns / 1ps

module watlr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  watlr_pkg::stat_t  stat_i,
  output watlr_pkg::cmd_t   cmd_o
);

  watlr_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= watlr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      watlr_pkg::ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) state_d = watlr_pkg::ST_EXEC;
      end
      watlr_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (stat_i.need_scan)      state_d = watlr_pkg::ST_SCAN_RD;
        else if (stat_i.need_move) state_d = watlr_pkg::ST_MOVE_RD;
        else                       state_d = watlr_pkg::ST_FINISH;
      end
      watlr_pkg::ST_SCAN_RD: begin
        cmd_o.scan_rd = 1'b1;
        state_d = stat_i.scan_end ? watlr_pkg::ST_FINISH : watlr_pkg::ST_SCAN_CMP;
      end
      watlr_pkg::ST_SCAN_CMP: begin
        cmd_o.scan_cmp = 1'b1;
        state_d = stat_i.scan_hit ? watlr_pkg::ST_START_A : watlr_pkg::ST_SCAN_RD;
      end
      watlr_pkg::ST_START_A: begin
        cmd_o.start_a = 1'b1;
        state_d = watlr_pkg::ST_START_B;
      end
      watlr_pkg::ST_START_B: begin
        cmd_o.start_b = 1'b1;
        state_d = watlr_pkg::ST_FINISH;
      end
      watlr_pkg::ST_MOVE_RD: begin
        cmd_o.move_rd = 1'b1;
        state_d = watlr_pkg::ST_MOVE_WR;
      end
      watlr_pkg::ST_MOVE_WR: begin
        cmd_o.move_wr = 1'b1;
        state_d = watlr_pkg::ST_FINISH;
      end
      watlr_pkg::ST_FINISH: begin
        cmd_o.finish = 1'b1;
        // wait here while the previous result beat is still stalled
        if (!stat_i.out_busy) state_d = watlr_pkg::ST_IDLE;
      end
      default: begin
        state_d = watlr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/watlr_dp.sv @@
`timescale 1ns / 1ps

module watlr_dp #(
  parameter int MAX_ALARMS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  watlr_pkg::cmd_t   cmd_i,
  output watlr_pkg::stat_t  stat_o,

  input  logic              cfg_valid_i,
  input  logic [15:0]       cfg_data_i,

  input  logic [2:0]        action_i,
  input  logic [7:0]        slot_i,
  input  logic [7:0]        enable_value_i,
  input  logic [6:0]        day_mask_i,
  input  logic [4:0]        alarm_hour_i,
  input  logic [5:0]        alarm_minute_i,
  input  logic [7:0]        rise_minutes_i,
  input  logic [7:0]        hold_minutes_i,
  input  logic [2:0]        now_weekday_i,
  input  logic [4:0]        now_hour_i,
  input  logic [5:0]        now_minute_i,

  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        light_level_o,
  output logic              ramp_active_o,
  output logic [7:0]        running_slot_o,
  output logic              status_o,
  output logic [7:0]        alarm_count_o
);

  localparam int AW = (MAX_ALARMS > 1) ? $clog2(MAX_ALARMS) : 1;
  localparam int BODY_W = 34;  // days, hour, minute, rise, hold
  localparam logic [8:0] MAX_EXT = 9'(MAX_ALARMS);

  // captured item
  logic [2:0] act_q;
  logic [7:0] slot_q, en_q, rise_q, hold_in_q;
  logic [6:0] days_q;
  logic [4:0] ahr_q, nhr_q;
  logic [5:0] amin_q, nmin_q;
  logic [2:0] wday_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q     <= action_i;
      slot_q    <= slot_i;
      en_q      <= enable_value_i;
      days_q    <= day_mask_i;
      ahr_q     <= alarm_hour_i;
      amin_q    <= alarm_minute_i;
      rise_q    <= rise_minutes_i;
      hold_in_q <= hold_minutes_i;
      wday_q    <= now_weekday_i;
      nhr_q     <= now_hour_i;
      nmin_q    <= now_minute_i;
    end
  end

  // state
  logic [15:0] check_q, check_d;
  logic [7:0]  count_q, count_d;
  logic [31:0] elapsed_q, elapsed_d;
  logic        ramp_q, ramp_d;
  logic [7:0]  level_q, level_d;
  logic [15:0] step_q, step_d;
  logic [23:0] hold_q, hold_d;
  logic [7:0]  fired_q, fired_d;
  logic        stat_q, stat_d;
  logic [7:0]  scan_idx_q, scan_idx_d;
  logic [15:0] p_int_q, p_int_d;
  logic [18:0] p_frac_q, p_frac_d;
  logic        out_valid_q, out_valid_d;

  // table memory
  logic [7:0]        en_mem [MAX_ALARMS];
  logic [BODY_W-1:0] body_mem [MAX_ALARMS];
  logic [7:0]        rd_en_q;
  logic [BODY_W-1:0] rd_body_q;
  logic              we_en, we_body, rd_req;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [7:0]        wr_en_data;
  logic [BODY_W-1:0] wr_body_data;

  always_ff @(posedge clk_i) begin
    if (we_en)   en_mem[wr_addr]   <= wr_en_data;
    if (we_body) body_mem[wr_addr] <= wr_body_data;
    if (rd_req) begin
      rd_en_q   <= en_mem[rd_addr];
      rd_body_q <= body_mem[rd_addr];
    end
  end

  logic [6:0] rd_days;
  logic [4:0] rd_hour;
  logic [5:0] rd_minute;
  logic [7:0] rd_rise, rd_hold;
  assign {rd_days, rd_hour, rd_minute, rd_rise, rd_hold} = rd_body_q;

  // decode helpers
  logic [31:0] e_inc;
  logic [8:0]  slot_ext, cnt_ext;
  logic        save_bad, rem_bad, en_bad, tick_scan;
  logic [7:0]  slot_idx, last_idx;
  logic [3:0]  wday_shift;
  logic [2:0]  day_bit;
  logic [23:0] hold_prod;
  logic [15:0] int_prod;
  logic [18:0] frac_prod;

  assign e_inc     = (elapsed_q == '1) ? elapsed_q : elapsed_q + 32'd1;
  assign slot_ext  = {1'b0, slot_q};
  assign cnt_ext   = {1'b0, count_q};
  assign save_bad  = (slot_q == 8'd0) || (slot_ext > cnt_ext + 9'd1) || (slot_ext > MAX_EXT);
  assign rem_bad   = (slot_q == 8'd0) || (slot_q > count_q) || (cnt_ext > MAX_EXT);
  assign en_bad    = (slot_q == 8'd0) || (slot_q > count_q) || (slot_ext > MAX_EXT);
  assign slot_idx  = slot_q - 8'd1;
  assign last_idx  = count_q - 8'd1;
  assign tick_scan = !ramp_q && (e_inc >= {16'd0, check_q});

  // Monday-first day index, weekday above six wraps
  assign wday_shift = {1'b0, wday_q} + 4'd6;
  assign day_bit    = (wday_shift >= 4'd7) ? 3'(wday_shift - 4'd7) : wday_shift[2:0];

  assign hold_prod = 24'(rd_hold) * 24'(watlr_pkg::MS_PER_MIN);
  assign int_prod  = 16'(rd_rise) * 16'(watlr_pkg::RISE_INT_MULT);
  assign frac_prod = 19'(rd_rise) * 19'(watlr_pkg::RISE_FRAC_MULT);

  assign stat_o.need_scan = (act_q == watlr_pkg::ACT_TICK) && tick_scan;
  assign stat_o.need_move = (act_q == watlr_pkg::ACT_REMOVE) && !rem_bad && (slot_q < count_q);
  assign stat_o.scan_end  = (scan_idx_q >= count_q) || ({1'b0, scan_idx_q} >= MAX_EXT);
  assign stat_o.scan_hit  = (rd_en_q == watlr_pkg::ENABLE_ON) && rd_days[day_bit] &&
                            (rd_hour == nhr_q) && (rd_minute == nmin_q);
  assign stat_o.out_busy  = out_valid_q && out_stall_i;

  always_comb begin
    check_d      = check_q;
    count_d      = count_q;
    elapsed_d    = elapsed_q;
    ramp_d       = ramp_q;
    level_d      = level_q;
    step_d       = step_q;
    hold_d       = hold_q;
    fired_d      = fired_q;
    stat_d       = stat_q;
    scan_idx_d   = scan_idx_q;
    p_int_d      = p_int_q;
    p_frac_d     = p_frac_q;
    out_valid_d  = out_valid_q;
    we_en        = 1'b0;
    we_body      = 1'b0;
    wr_addr      = slot_idx[AW-1:0];
    wr_en_data   = en_q;
    wr_body_data = {days_q, ahr_q, amin_q, rise_q, hold_in_q};
    rd_req       = 1'b0;
    rd_addr      = scan_idx_q[AW-1:0];

    if (cfg_valid_i) check_d = cfg_data_i;

    if (cmd_i.exec) begin
      stat_d = 1'b0;
      case (act_q)
        watlr_pkg::ACT_TICK: begin
          elapsed_d = e_inc;
          if (ramp_q) begin
            if (level_q == watlr_pkg::FULL_LEVEL) begin
              if (e_inc >= {8'd0, hold_q}) begin
                elapsed_d = '0;
                level_d   = '0;
                ramp_d    = 1'b0;
              end
            end else if (e_inc >= {16'd0, step_q}) begin
              elapsed_d = '0;
              level_d   = level_q + 8'd1;
            end
          end else if (tick_scan) begin
            elapsed_d  = '0;
            scan_idx_d = '0;
          end
        end
        watlr_pkg::ACT_SAVE: begin
          if (save_bad) begin
            stat_d = 1'b1;
          end else begin
            we_en   = 1'b1;
            we_body = 1'b1;
            if (slot_q > count_q) count_d = count_q + 8'd1;
          end
        end
        watlr_pkg::ACT_REMOVE: begin
          if (rem_bad) begin
            stat_d = 1'b1;
          end else if (slot_q == count_q) begin
            count_d = last_idx;
          end
        end
        watlr_pkg::ACT_SET_EN: begin
          if (en_bad) stat_d = 1'b1;
          else        we_en  = 1'b1;
        end
        watlr_pkg::ACT_CLEAR: begin
          count_d = '0;
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.scan_rd) begin
      if (stat_o.scan_end) fired_d = '0;
      else                 rd_req  = 1'b1;
    end

    if (cmd_i.scan_cmp) begin
      if (stat_o.scan_hit) fired_d    = scan_idx_q + 8'd1;
      else                 scan_idx_d = scan_idx_q + 8'd1;
    end

    if (cmd_i.start_a) begin
      level_d  = '0;
      ramp_d   = 1'b1;
      hold_d   = hold_prod;
      p_int_d  = int_prod;
      p_frac_d = frac_prod;
    end

    if (cmd_i.start_b) begin
      step_d = p_int_q + 16'(p_frac_q >> watlr_pkg::RISE_FRAC_SHIFT);
    end

    // move the last entry into the freed slot
    if (cmd_i.move_rd) begin
      rd_req  = 1'b1;
      rd_addr = last_idx[AW-1:0];
    end

    if (cmd_i.move_wr) begin
      we_en        = 1'b1;
      we_body      = 1'b1;
      wr_en_data   = rd_en_q;
      wr_body_data = rd_body_q;
      count_d      = last_idx;
    end

    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_i.finish && !stat_o.out_busy) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_q     <= watlr_pkg::CHECK_RESET;
      count_q     <= '0;
      elapsed_q   <= '0;
      ramp_q      <= 1'b0;
      level_q     <= '0;
      step_q      <= watlr_pkg::STEP_RESET;
      hold_q      <= watlr_pkg::HOLD_RESET;
      fired_q     <= '0;
      stat_q      <= 1'b0;
      scan_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      check_q     <= check_d;
      count_q     <= count_d;
      elapsed_q   <= elapsed_d;
      ramp_q      <= ramp_d;
      level_q     <= level_d;
      step_q      <= step_d;
      hold_q      <= hold_d;
      fired_q     <= fired_d;
      stat_q      <= stat_d;
      scan_idx_q  <= scan_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_int_q  <= p_int_d;
    p_frac_q <= p_frac_d;
  end

  // result beat register
  logic [7:0] out_level_q, out_slot_q, out_count_q;
  logic       out_ramp_q, out_stat_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && !stat_o.out_busy) begin
      out_level_q <= level_q;
      out_ramp_q  <= ramp_q;
      out_slot_q  <= fired_q;
      out_stat_q  <= stat_q;
      out_count_q <= count_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign light_level_o  = out_level_q;
  assign ramp_active_o  = out_ramp_q;
  assign running_slot_o = out_slot_q;
  assign status_o       = out_stat_q;
  assign alarm_count_o  = out_count_q;

  a_level_needs_ramp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q != 8'd0 |-> ramp_q)
    else $error("light level nonzero outside a ramp");

  a_ramp_has_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ramp_q |-> fired_q != 8'd0)
    else $error("ramp running without a fired slot");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_ext <= MAX_EXT)
    else $error("alarm count beyond table size");

  a_move_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.move_wr |-> $past(cmd_i.move_rd))
    else $error("entry move written without a preceding read");

endmodule

@@ src/weekly_alarm_table_with_light_ramp.sv @@
`timescale 1ns / 1ps

// Weekly alarm table with a sunrise light ramp. Items arrive one at a time on a
// valid/stall channel and each produces one result beat; action 0 is a 1 ms tick,
// actions 1 to 4 edit the table (save or append, remove by moving the last entry,
// set enable, clear all). A table edit or a tick passes through EXEC and FINISH
// after acceptance; a remove that moves an entry also passes through MOVE_RD and
// MOVE_WR. A tick that scans the table passes through SCAN_RD and SCAN_CMP for
// each entry examined, then START_A and START_B when an alarm fires, since the
// table memory has a single read port (each entry is read, then compared). A
// stalled result beat holds the controller in its final state until taken. The
// check-interval register may be written at any time the block is idle; cfg_ready_o
// is always high. Table contents are undefined until saved.
module weekly_alarm_table_with_light_ramp #(
  parameter int MAX_ALARMS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic [7:0]  slot_i,
  input  logic [7:0]  enable_value_i,
  input  logic [6:0]  day_mask_i,
  input  logic [4:0]  alarm_hour_i,
  input  logic [5:0]  alarm_minute_i,
  input  logic [7:0]  rise_minutes_i,
  input  logic [7:0]  hold_minutes_i,
  input  logic [2:0]  now_weekday_i,
  input  logic [4:0]  now_hour_i,
  input  logic [5:0]  now_minute_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  light_level_o,
  output logic        ramp_active_o,
  output logic [7:0]  running_slot_o,
  output logic        status_o,
  output logic [7:0]  alarm_count_o
);

  watlr_pkg::cmd_t  cmd;
  watlr_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  watlr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  watlr_dp #(
    .MAX_ALARMS (MAX_ALARMS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .action_i       (action_i),
    .slot_i         (slot_i),
    .enable_value_i (enable_value_i),
    .day_mask_i     (day_mask_i),
    .alarm_hour_i   (alarm_hour_i),
    .alarm_minute_i (alarm_minute_i),
    .rise_minutes_i (rise_minutes_i),
    .hold_minutes_i (hold_minutes_i),
    .now_weekday_i  (now_weekday_i),
    .now_hour_i     (now_hour_i),
    .now_minute_i   (now_minute_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .light_level_o  (light_level_o),
    .ramp_active_o  (ramp_active_o),
    .running_slot_o (running_slot_o),
    .status_o       (status_o),
    .alarm_count_o  (alarm_count_o)
  );

endmodule

@@ sim/weekly_alarm_table_with_light_ramp_tb.sv @@
`timescale 1ns / 1ps

module weekly_alarm_table_with_light_ramp_tb;

  localparam int MAX_ALARMS = 16;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 48;
  localparam int PHASE_ITEMS = 160;
  localparam int SLOW_RAMP_TICKS = 600;
  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;
  localparam logic [6:0] DAYS_ALL = 7'h7f;
  localparam int SUNDAY_BIT = 6;

  typedef struct packed {
    logic [7:0] en;
    logic [6:0] days;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [7:0] rise;
    logic [7:0] hold;
  } alarm_t;

  typedef struct {
    logic [2:0] act;
    logic [7:0] slot;
    logic [7:0] en;
    logic [6:0] days;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [7:0] rise;
    logic [7:0] hold;
    logic [2:0] wday;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
  } lamp_item_t;

  typedef struct packed {
    logic [7:0] level;
    logic       active;
    logic [7:0] slot;
    logic       status;
    logic [7:0] count;
  } lamp_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  action_i;
  logic [7:0]  slot_i;
  logic [7:0]  enable_value_i;
  logic [6:0]  day_mask_i;
  logic [4:0]  alarm_hour_i;
  logic [5:0]  alarm_minute_i;
  logic [7:0]  rise_minutes_i;
  logic [7:0]  hold_minutes_i;
  logic [2:0]  now_weekday_i;
  logic [4:0]  now_hour_i;
  logic [5:0]  now_minute_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  light_level_o;
  logic        ramp_active_o;
  logic [7:0]  running_slot_o;
  logic        status_o;
  logic [7:0]  alarm_count_o;

  weekly_alarm_table_with_light_ramp #(
    .MAX_ALARMS(MAX_ALARMS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .slot_i         (slot_i),
    .enable_value_i (enable_value_i),
    .day_mask_i     (day_mask_i),
    .alarm_hour_i   (alarm_hour_i),
    .alarm_minute_i (alarm_minute_i),
    .rise_minutes_i (rise_minutes_i),
    .hold_minutes_i (hold_minutes_i),
    .now_weekday_i  (now_weekday_i),
    .now_hour_i     (now_hour_i),
    .now_minute_i   (now_minute_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .light_level_o  (light_level_o),
    .ramp_active_o  (ramp_active_o),
    .running_slot_o (running_slot_o),
    .status_o       (status_o),
    .alarm_count_o  (alarm_count_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // predicted block state
  alarm_t      tbl [MAX_ALARMS];
  logic [7:0]  tbl_count;
  logic [31:0] ms_since;
  logic        ramp_on;
  logic [7:0]  lamp;
  logic [31:0] step_ms;
  logic [31:0] hold_ms_ref;
  logic [7:0]  hit_slot;
  logic [15:0] scan_ms;

  lamp_result_t lamp_expect_q [$];
  int unsigned  errors = 0;
  int unsigned  cycle_count = 0;
  bit           idle_on = 1'b1;
  bit           allow_slow = 1'b0;

  function automatic logic [7:0] find_alarm(logic [2:0] wday, logic [4:0] hr, logic [5:0] mn);
    int day_bit;
    day_bit = (int'(wday) + 6) % 7;
    for (int i = 1; i <= int'(tbl_count) && i <= MAX_ALARMS; i++) begin
      if (tbl[i-1].en == watlr_pkg::ENABLE_ON && tbl[i-1].days[day_bit] &&
          tbl[i-1].hour == hr && tbl[i-1].minute == mn)
        return 8'(i);
    end
    return 8'd0;
  endfunction

  function automatic lamp_result_t step_alarm_table(lamp_item_t it);
    lamp_result_t r;
    logic [7:0]   hit;
    logic         st;
    st = 1'b0;
    case (it.act)
      watlr_pkg::ACT_TICK: begin
        if (ms_since != '1) ms_since++;
        if (ramp_on) begin
          if (lamp == watlr_pkg::FULL_LEVEL) begin
            if (ms_since >= hold_ms_ref) begin
              ms_since = '0;
              lamp = '0;
              ramp_on = 1'b0;
            end
          end else if (ms_since >= step_ms) begin
            ms_since = '0;
            lamp++;
          end
        end else if (ms_since >= 32'(scan_ms)) begin
          ms_since = '0;
          hit = find_alarm(it.wday, it.now_hour, it.now_minute);
          hit_slot = hit;
          if (hit != 0) begin
            step_ms = 32'(tbl[hit-1].rise) * 32'(watlr_pkg::MS_PER_MIN) /
                      32'(watlr_pkg::FULL_LEVEL);
            hold_ms_ref = 32'(tbl[hit-1].hold) * 32'(watlr_pkg::MS_PER_MIN);
            lamp = '0;
            ramp_on = 1'b1;
          end
        end
      end
      watlr_pkg::ACT_SAVE: begin
        if (it.slot == 0 || int'(it.slot) > int'(tbl_count) + 1 || it.slot > MAX_ALARMS) begin
          st = 1'b1;
        end else begin
          if (it.slot > tbl_count) tbl_count++;
          tbl[it.slot-1] = '{en: it.en, days: it.days, hour: it.hour, minute: it.minute,
                             rise: it.rise, hold: it.hold};
        end
      end
      watlr_pkg::ACT_REMOVE: begin
        if (it.slot == 0 || it.slot > tbl_count || tbl_count > MAX_ALARMS) begin
          st = 1'b1;
        end else begin
          if (it.slot < tbl_count) tbl[it.slot-1] = tbl[tbl_count-1];
          tbl_count--;
        end
      end
      watlr_pkg::ACT_SET_EN: begin
        if (it.slot == 0 || it.slot > tbl_count || it.slot > MAX_ALARMS) st = 1'b1;
        else tbl[it.slot-1].en = it.en;
      end
      watlr_pkg::ACT_CLEAR: tbl_count = '0;
      default: ;
    endcase
    r = '{level: lamp, active: ramp_on, slot: hit_slot, status: st, count: tbl_count};
    return r;
  endfunction

  // true when this tick would start a ramp too long for the run
  function automatic bit slow_alarm_due(lamp_item_t it);
    logic [7:0]  hit;
    logic [31:0] nxt;
    if (allow_slow || ramp_on) return 1'b0;
    nxt = (ms_since == '1) ? ms_since : ms_since + 1;
    if (nxt < 32'(scan_ms)) return 1'b0;
    hit = find_alarm(it.wday, it.now_hour, it.now_minute);
    return hit != 0 && (tbl[hit-1].rise != 0 || tbl[hit-1].hold != 0);
  endfunction

  function automatic lamp_item_t noise_item();
    lamp_item_t it;
    it.act        = watlr_pkg::ACT_TICK;
    it.slot       = 8'($urandom_range(0, 255));
    it.en         = 8'($urandom_range(0, 255));
    it.days       = 7'($urandom_range(0, 127));
    it.hour       = 5'($urandom_range(0, 23));
    it.minute     = 6'($urandom_range(0, 59));
    it.rise       = 8'($urandom_range(0, 255));
    it.hold       = 8'($urandom_range(0, 255));
    it.wday       = 3'($urandom_range(0, 7));
    it.now_hour   = 5'($urandom_range(0, 23));
    it.now_minute = 6'($urandom_range(0, 59));
    return it;
  endfunction

  function automatic lamp_item_t tick_at(logic [2:0] wd, logic [4:0] h, logic [5:0] m);
    lamp_item_t it;
    it = noise_item();
    it.act = watlr_pkg::ACT_TICK;
    it.wday = wd;
    it.now_hour = h;
    it.now_minute = m;
    return it;
  endfunction

  function automatic lamp_item_t save_item(logic [7:0] slot, logic [7:0] en, logic [6:0] days,
                                           logic [4:0] h, logic [5:0] m,
                                           logic [7:0] rise, logic [7:0] hold);
    lamp_item_t it;
    it = noise_item();
    it.act = watlr_pkg::ACT_SAVE;
    it.slot = slot;
    it.en = en;
    it.days = days;
    it.hour = h;
    it.minute = m;
    it.rise = rise;
    it.hold = hold;
    return it;
  endfunction

  function automatic lamp_item_t table_item(logic [2:0] act, logic [7:0] slot, logic [7:0] en);
    lamp_item_t it;
    it = noise_item();
    it.act = act;
    it.slot = slot;
    it.en = en;
    return it;
  endfunction

  task automatic send_item(lamp_item_t it);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    action_i       <= it.act;
    slot_i         <= it.slot;
    enable_value_i <= it.en;
    day_mask_i     <= it.days;
    alarm_hour_i   <= it.hour;
    alarm_minute_i <= it.minute;
    rise_minutes_i <= it.rise;
    hold_minutes_i <= it.hold;
    now_weekday_i  <= it.wday;
    now_hour_i     <= it.now_hour;
    now_minute_i   <= it.now_minute;
    do @(posedge clk_i); while (in_stall_o);
    lamp_expect_q.push_back(step_alarm_table(it));
  endtask

  task automatic wait_results_in();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (lamp_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_scan_interval(logic [15:0] ms);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= ms;
    do @(posedge clk_i); while (!cfg_ready_o);
    scan_ms = ms;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  // aim some ticks at a stored alarm so that scans hit
  task automatic random_tick();
    lamp_item_t it;
    int k;
    int b;
    it = tick_at(3'($urandom_range(0, 7)), 5'($urandom_range(0, 23)),
                 6'($urandom_range(0, 59)));
    if (tbl_count != 0 && $urandom_range(0, 99) < 15) begin
      k = $urandom_range(0, int'(tbl_count) - 1);
      it.now_hour = tbl[k].hour;
      it.now_minute = tbl[k].minute;
      b = $urandom_range(0, 6);
      for (int j = 0; j < 7; j++) begin
        if (tbl[k].days[(b + j) % 7]) begin
          b = (b + j) % 7;
          break;
        end
      end
      // Sunday is weekday 0 and, past the wrap, weekday 7 too
      if (b == SUNDAY_BIT && $urandom_range(0, 1) == 1) it.wday = 3'd7;
      else it.wday = 3'((b + 1) % 7);
    end
    while (slow_alarm_due(it)) begin
      it.now_hour = 5'($urandom_range(0, 23));
      it.now_minute = 6'($urandom_range(0, 59));
    end
    send_item(it);
  endtask

  function automatic logic [7:0] pick_slot(bit append_ok);
    int top;
    top = append_ok ? ((tbl_count < MAX_ALARMS) ? int'(tbl_count) + 1 : MAX_ALARMS)
                    : int'(tbl_count);
    if (top > 0 && $urandom_range(0, 4) != 0) return 8'($urandom_range(1, top));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic random_item();
    int r;
    bit quick;
    r = $urandom_range(0, 99);
    quick = $urandom_range(0, 4) != 0;
    if (r < 60) begin
      random_tick();
    end else if (r < 80) begin
      send_item(save_item(pick_slot(1'b1),
                          ($urandom_range(0, 3) != 0) ? watlr_pkg::ENABLE_ON
                                                      : 8'($urandom_range(0, 255)),
                          ($urandom_range(0, 3) == 0) ? DAYS_ALL : 7'($urandom_range(0, 127)),
                          5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)),
                          quick ? 8'd0 : 8'($urandom_range(0, 255)),
                          quick ? 8'd0 : 8'($urandom_range(0, 255))));
    end else if (r < 88) begin
      send_item(table_item(watlr_pkg::ACT_REMOVE, pick_slot(1'b0),
                           8'($urandom_range(0, 255))));
    end else if (r < 96) begin
      send_item(table_item(watlr_pkg::ACT_SET_EN, pick_slot(1'b0),
                           ($urandom_range(0, 1) == 1) ? watlr_pkg::ENABLE_ON
                                                        : 8'($urandom_range(0, 255))));
    end else if (r < 98) begin
      send_item(table_item(watlr_pkg::ACT_CLEAR, 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255))));
    end else begin
      send_item(table_item(3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)),
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
    end
  endtask

  task automatic test_power_on();
    send_item(tick_at(3'd0, 5'd0, 6'd0));
    send_item(tick_at(3'd6, 5'd23, 6'd59));
    send_item(table_item(ACT_SPARE_LO, 8'd1, 8'd1));
    send_item(table_item(ACT_SPARE_HI, 8'd255, 8'd255));
    send_item(table_item(watlr_pkg::ACT_CLEAR, 8'd0, 8'd0));
    send_item(table_item(watlr_pkg::ACT_REMOVE, 8'd1, 8'd0));
    send_item(table_item(watlr_pkg::ACT_SET_EN, 8'd1, watlr_pkg::ENABLE_ON));
  endtask

  task automatic test_table_edits();
    send_item(save_item(8'd0, watlr_pkg::ENABLE_ON, DAYS_ALL, 5'd1, 6'd1, 8'd0, 8'd0));
    send_item(save_item(8'd2, watlr_pkg::ENABLE_ON, DAYS_ALL, 5'd1, 6'd1, 8'd0, 8'd0));
    send_item(save_item(8'd1, 8'd255, DAYS_ALL, 5'd23, 6'd59, 8'd255, 8'd255));
    send_item(save_item(8'd2, 8'd0, 7'd0, 5'd0, 6'd0, 8'd0, 8'd0));
    send_item(save_item(8'd3, watlr_pkg::ENABLE_ON, 7'h2a, 5'd12, 6'd30, 8'd0, 8'd0));
    send_item(save_item(8'd2, watlr_pkg::ENABLE_ON, 7'h55, 5'd8, 6'd15, 8'd0, 8'd0));
    send_item(table_item(watlr_pkg::ACT_SET_EN, 8'd0, watlr_pkg::ENABLE_ON));
    send_item(table_item(watlr_pkg::ACT_SET_EN, 8'd4, watlr_pkg::ENABLE_ON));
    send_item(table_item(watlr_pkg::ACT_SET_EN, 8'd1, watlr_pkg::ENABLE_ON));
    send_item(table_item(watlr_pkg::ACT_SET_EN, 8'd1, 8'd0));
    send_item(table_item(watlr_pkg::ACT_REMOVE, 8'd0, 8'd0));
    send_item(table_item(watlr_pkg::ACT_REMOVE, 8'd4, 8'd0));
    // first entry gets overwritten by the last one
    send_item(table_item(watlr_pkg::ACT_REMOVE, 8'd1, 8'd0));
    send_item(table_item(watlr_pkg::ACT_REMOVE, 8'd2, 8'd0));
    send_item(save_item(8'd255, watlr_pkg::ENABLE_ON, DAYS_ALL, 5'd1, 6'd1, 8'd0, 8'd0));
    send_item(table_item(watlr_pkg::ACT_CLEAR, 8'd0, 8'd0));
  endtask

  task automatic test_scan_hit();
    send_item(save_item(8'd1, watlr_pkg::ENABLE_ON, 7'h40, 5'd6, 6'd30, 8'd0, 8'd0));
    send_item(tick_at(3'd1, 5'd6, 6'd30));
    send_item(tick_at(3'd7, 5'd6, 6'd30));
    send_item(tick_at(3'd0, 5'd6, 6'd30));
    send_item(table_item(watlr_pkg::ACT_SET_EN, 8'd1, 8'd0));
    send_item(save_item(8'd2, watlr_pkg::ENABLE_ON, DAYS_ALL, 5'd6, 6'd31, 8'd0, 8'd0));
    send_item(tick_at(3'd0, 5'd6, 6'd31));
  endtask

  task automatic test_random_traffic();
    logic [15:0] ms;
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: ms = 16'd1;
        1: ms = 16'hffff;
        2: ms = 16'd0;
        default: ms = 16'($urandom_range(1, 12));
      endcase
      wait_results_in();
      set_scan_interval(ms);
      idle_on = (p != 3);
      repeat (PHASE_ITEMS) random_item();
    end
    idle_on = 1'b1;
  endtask

  // let one alarm with a real rise time fire and step a few levels
  task automatic test_slow_ramp();
    logic [4:0] h;
    logic [5:0] m;
    send_item(table_item(watlr_pkg::ACT_CLEAR, 8'd0, 8'd0));
    while (ramp_on) random_tick();
    wait_results_in();
    set_scan_interval(16'd1);
    h = 5'($urandom_range(0, 23));
    m = 6'($urandom_range(0, 59));
    allow_slow = 1'b1;
    send_item(save_item(8'd1, watlr_pkg::ENABLE_ON, DAYS_ALL, h, m, 8'($urandom_range(1, 2)),
                        8'($urandom_range(0, 255))));
    send_item(tick_at(3'($urandom_range(0, 7)), h, m));
    repeat (SLOW_RAMP_TICKS) random_tick();
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("weekly_alarm_table_with_light_ramp_tb: errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    lamp_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (lamp_expect_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none actual level %0d slot %0d count %0d",
                 $time, light_level_o, running_slot_o, alarm_count_o);
        errors++;
      end else begin
        want = lamp_expect_q.pop_front();
        check_field("light_level", want.level, light_level_o);
        check_field("ramp_active", want.active, ramp_active_o);
        check_field("running_slot", want.slot, running_slot_o);
        check_field("status", want.status, status_o);
        check_field("alarm_count", want.count, alarm_count_o);
      end
    end
  end

  // result side back-pressure
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = idle_on ? $urandom_range(0, 5) : 0;
      if (n > 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (n - 1) @(negedge clk_i);
        @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    action_i       = watlr_pkg::ACT_TICK;
    slot_i         = '0;
    enable_value_i = '0;
    day_mask_i     = '0;
    alarm_hour_i   = '0;
    alarm_minute_i = '0;
    rise_minutes_i = '0;
    hold_minutes_i = '0;
    now_weekday_i  = '0;
    now_hour_i     = '0;
    now_minute_i   = '0;
    out_stall_i    = 1'b0;
    for (int i = 0; i < MAX_ALARMS; i++) tbl[i] = '0;
    tbl_count   = '0;
    ms_since    = '0;
    ramp_on     = 1'b0;
    lamp        = '0;
    step_ms     = 32'(watlr_pkg::STEP_RESET);
    hold_ms_ref = 32'(watlr_pkg::HOLD_RESET);
    hit_slot    = '0;
    scan_ms     = watlr_pkg::CHECK_RESET;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_power_on();
    test_table_edits();
    wait_results_in();
    set_scan_interval(16'd0);
    test_scan_hit();
    test_random_traffic();
    test_slow_ramp();
    wait_results_in();

    if (errors == 0) $display("weekly_alarm_table_with_light_ramp_tb: clean");
    else $display("weekly_alarm_table_with_light_ramp_tb: errors");
    $finish;
  end

endmodule
